/* sv/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants for the point to segment distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

  // default coordinate width, signed Q16.16
  localparam int COORD_WIDTH_DEF = 32;
  // default fraction bits of the segment parameter t
  localparam int T_FRAC_BITS_DEF = 16;

endpackage

/* sv/psd_if.sv */
// ----------------------------------------------------------------------------
// psd_in_if / psd_out_if
// Valid/ready channels carrying a segment query and its result.
// ----------------------------------------------------------------------------
interface psd_in_if #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] start_z;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] end_z;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  point_x, point_y, input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  point_x, point_y, output ready);
endinterface

interface psd_out_if #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic        [COORD_WIDTH:0]   distance;
  logic signed [COORD_WIDTH-1:0] closest_x;
  logic signed [COORD_WIDTH-1:0] closest_y;
  logic signed [COORD_WIDTH-1:0] closest_z;

  modport source (output valid, distance, closest_x, closest_y, closest_z,
                  input ready);
  modport sink   (input valid, distance, closest_x, closest_y, closest_z,
                  output ready);
endinterface

/* sv/point_segment_distance_xy.sv */
// ----------------------------------------------------------------------------
// point_segment_distance_xy
// XY distance from a point to a segment, with the closest point on it.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink) takes one query per transaction: segment start and end
//   (x, y, z) and a point (x, y), all signed fixed point.
//   rsp (source) returns one result per query, in order: the closest point
//   on the segment (x, y, z) and the floor of the XY distance to it.
// Throughput: one transaction per cycle, sustained while rsp takes results.
// Pipeline: stages a, b and c, the pipelined divider (one quotient bit per
//   stage), the interpolation, error and squares stages and the pipelined
//   square root (one root bit per stage), all registered, ahead of rsp.valid.
// Stall: the whole pipeline freezes while rsp holds a result that is not
//   taken; req.ready is low only then, and nothing is lost or repeated.
// Reset: rst (synchronous) clears every stage valid bit; data registers
//   are not reset.
// ----------------------------------------------------------------------------
module point_segment_distance_xy #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = psd_pkg::T_FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  psd_in_if.sink   req,
  psd_out_if.source rsp
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = T_FRAC_BITS;
  localparam int PW  = 2 * W + 2;      // product / a width
  localparam int RW  = 2 * W + 3;      // remainder width
  localparam int MW  = W + F + 3;      // interpolation product width
  localparam int DV0 = 2;              // first divider stage
  localparam int STD = F + 3;          // interpolation multiply
  localparam int STE = F + 4;          // closest point and error
  localparam int STF = F + 5;          // squares
  localparam int SQ0 = F + 6;          // first root stage
  localparam int NST = W + F + 8;

  logic           en;
  logic [NST-1:0] vld;

  // stage a: differences
  logic signed [W:0]   a_dx, a_dy, a_dz, a_wx, a_wy;
  logic signed [W-1:0] a_sx, a_sy, a_sz, a_px, a_py;
  // stage b: products
  logic signed [PW-1:0] b_ddx, b_ddy, b_dwx, b_dwy;
  logic signed [W:0]    b_dx, b_dy, b_dz;
  logic signed [W-1:0]  b_sx, b_sy, b_sz, b_px, b_py;
  // divider stages
  logic [PW-1:0]        dv_a    [0:F];
  logic [RW-1:0]        dv_rem  [0:F];
  logic [F-1:0]         dv_q    [0:F];
  logic                 dv_zero [0:F];
  logic                 dv_one  [0:F];
  logic signed [W:0]    dv_dx [0:F], dv_dy [0:F], dv_dz [0:F];
  logic signed [W-1:0]  dv_sx [0:F], dv_sy [0:F], dv_sz [0:F];
  logic signed [W-1:0]  dv_px [0:F], dv_py [0:F];
  // interpolation
  logic signed [MW-1:0] d_mx, d_my, d_mz;
  logic signed [W-1:0]  d_sx, d_sy, d_sz, d_px, d_py;
  logic [F:0]           t_val;
  logic signed [MW-1:0] sh_x, sh_y, sh_z;
  logic signed [W-1:0]  c_x_next, c_y_next;
  logic signed [W-1:0]  e_cx, e_cy, e_cz;
  logic signed [W:0]    e_ex, e_ey;
  logic signed [PW-1:0] f_qx, f_qy;
  logic signed [W-1:0]  f_cx, f_cy, f_cz;
  // root stages
  logic [RW-1:0]        sq_rem  [0:W+1];
  logic [W:0]           sq_root [0:W+1];
  logic signed [W-1:0]  sq_cx [0:W+1], sq_cy [0:W+1], sq_cz [0:W+1];

  logic signed [RW-1:0] b_sum;
  logic [RW-1:0]        b_mag;

  // global advance: move unless a finished result is held
  assign en        = !vld[NST-1] || rsp.ready;
  assign req.ready = en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], req.valid};
    end
  end

  // stage a: direction and start offset
  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= {req.end_x[W-1], req.end_x} - {req.start_x[W-1], req.start_x};
      a_dy <= {req.end_y[W-1], req.end_y} - {req.start_y[W-1], req.start_y};
      a_dz <= {req.end_z[W-1], req.end_z} - {req.start_z[W-1], req.start_z};
      a_wx <= {req.start_x[W-1], req.start_x} - {req.point_x[W-1], req.point_x};
      a_wy <= {req.start_y[W-1], req.start_y} - {req.point_y[W-1], req.point_y};
      a_sx <= req.start_x;
      a_sy <= req.start_y;
      a_sz <= req.start_z;
      a_px <= req.point_x;
      a_py <= req.point_y;
    end
  end

  // stage b: dot product terms
  always_ff @(posedge clk) begin
    if (en) begin
      b_ddx <= a_dx * a_dx;
      b_ddy <= a_dy * a_dy;
      b_dwx <= a_dx * a_wx;
      b_dwy <= a_dy * a_wy;
      b_dx  <= a_dx;
      b_dy  <= a_dy;
      b_dz  <= a_dz;
      b_sx  <= a_sx;
      b_sy  <= a_sy;
      b_sz  <= a_sz;
      b_px  <= a_px;
      b_py  <= a_py;
    end
  end

  // stage c: |d|^2, projection and clamp decision
  assign b_sum = {b_dwx[PW-1], b_dwx} + {b_dwy[PW-1], b_dwy};
  assign b_mag = -b_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_a[0]    <= b_ddx + b_ddy;
      dv_rem[0]  <= b_mag;
      dv_q[0]    <= '0;
      dv_zero[0] <= ((b_ddx + b_ddy) == '0) || !b_sum[RW-1];
      dv_one[0]  <= b_sum[RW-1] && ((b_ddx + b_ddy) != '0) &&
                    (b_mag >= {1'b0, PW'(b_ddx + b_ddy)});
      dv_dx[0]   <= b_dx;
      dv_dy[0]   <= b_dy;
      dv_dz[0]   <= b_dz;
      dv_sx[0]   <= b_sx;
      dv_sy[0]   <= b_sy;
      dv_sz[0]   <= b_sz;
      dv_px[0]   <= b_px;
      dv_py[0]   <= b_py;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= F; k++) begin : g_div
    logic [RW-1:0] r2;
    logic          ge;
    assign r2 = {dv_rem[k-1][RW-2:0], 1'b0};
    assign ge = r2 >= {1'b0, dv_a[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k]  <= ge ? r2 - {1'b0, dv_a[k-1]} : r2;
        dv_q[k]    <= {dv_q[k-1][F-2:0], ge};
        dv_a[k]    <= dv_a[k-1];
        dv_zero[k] <= dv_zero[k-1];
        dv_one[k]  <= dv_one[k-1];
        dv_dx[k]   <= dv_dx[k-1];
        dv_dy[k]   <= dv_dy[k-1];
        dv_dz[k]   <= dv_dz[k-1];
        dv_sx[k]   <= dv_sx[k-1];
        dv_sy[k]   <= dv_sy[k-1];
        dv_sz[k]   <= dv_sz[k-1];
        dv_px[k]   <= dv_px[k-1];
        dv_py[k]   <= dv_py[k-1];
      end
    end
  end

  // clamped t and interpolation products
  always_comb begin
    if (dv_one[F]) begin
      t_val = {1'b1, {F{1'b0}}};
    end else if (dv_zero[F]) begin
      t_val = '0;
    end else begin
      t_val = {1'b0, dv_q[F]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_mx <= dv_dx[F] * $signed({1'b0, t_val});
      d_my <= dv_dy[F] * $signed({1'b0, t_val});
      d_mz <= dv_dz[F] * $signed({1'b0, t_val});
      d_sx <= dv_sx[F];
      d_sy <= dv_sy[F];
      d_sz <= dv_sz[F];
      d_px <= dv_px[F];
      d_py <= dv_py[F];
    end
  end

  // closest point (floor shift) and error vector
  assign sh_x     = d_mx >>> F;
  assign sh_y     = d_my >>> F;
  assign sh_z     = d_mz >>> F;
  assign c_x_next = d_sx + sh_x[W-1:0];
  assign c_y_next = d_sy + sh_y[W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      e_cx <= c_x_next;
      e_cy <= c_y_next;
      e_cz <= d_sz + sh_z[W-1:0];
      e_ex <= {c_x_next[W-1], c_x_next} - {d_px[W-1], d_px};
      e_ey <= {c_y_next[W-1], c_y_next} - {d_py[W-1], d_py};
    end
  end

  // squared error terms
  always_ff @(posedge clk) begin
    if (en) begin
      f_qx <= e_ex * e_ex;
      f_qy <= e_ey * e_ey;
      f_cx <= e_cx;
      f_cy <= e_cy;
      f_cz <= e_cz;
    end
  end

  // squared distance into the root pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= {1'b0, f_qx} + {1'b0, f_qy};
      sq_root[0] <= '0;
      sq_cx[0]   <= f_cx;
      sq_cy[0]   <= f_cy;
      sq_cz[0]   <= f_cz;
    end
  end

  // digit-by-digit square root, one root bit per stage, msb first
  for (genvar j = 1; j <= W + 1; j++) begin : g_sqrt
    localparam int I = W + 1 - j;
    logic [RW-1:0] trial;
    logic          take;
    assign trial = (RW'(sq_root[j-1]) << (I + 1)) + (RW'(1) << (2 * I));
    assign take  = trial <= sq_rem[j-1];
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[j]  <= take ? sq_rem[j-1] - trial : sq_rem[j-1];
        sq_root[j] <= sq_root[j-1] | ((W + 1)'(take) << I);
        sq_cx[j]   <= sq_cx[j-1];
        sq_cy[j]   <= sq_cy[j-1];
        sq_cz[j]   <= sq_cz[j-1];
      end
    end
  end

  // result
  assign rsp.valid     = vld[NST-1];
  assign rsp.distance  = sq_root[W+1];
  assign rsp.closest_x = sq_cx[W+1];
  assign rsp.closest_y = sq_cy[W+1];
  assign rsp.closest_z = sq_cz[W+1];

  // clamp to both ends at once is impossible
  a_clamp_excl: assert property (@(posedge clk) disable iff (rst)
    vld[DV0] |-> !(dv_zero[0] && dv_one[0]))
    else $error("t clamped to zero and one together");

  // divider remainder stays below the divisor on the interior path
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[STD-1] && !dv_zero[F] && !dv_one[F]) |-> (dv_rem[F] < {1'b0, dv_a[F]}))
    else $error("divider remainder not below divisor");

  // root is the floor: remainder at most twice the root
  a_sqrt_floor: assert property (@(posedge clk) disable iff (rst)
    vld[NST-1] |-> (sq_rem[W+1] <= {{(RW-W-2){1'b0}}, sq_root[W+1], 1'b0}))
    else $error("square root remainder too large");

  // a held result freezes the pipeline and blocks new queries
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && !rsp.ready) |=> (vld[NST-1] && $stable(sq_root[W+1])
                                    && $stable(vld)))
    else $error("held result changed during stall");

  // stage index sanity: the squares stage follows the error stage
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (en && vld[STE]) |=> vld[STF])
    else $error("valid bit lost between pipeline stages");

  // first root stage is fed by the squares stage
  a_sq_flow: assert property (@(posedge clk) disable iff (rst)
    (en && vld[STF]) |=> vld[SQ0])
    else $error("valid bit lost entering square root");

endmodule
